@@ hw/rtl/cpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, codes and control types of the padded 5x5 convolution core.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int IMG_SIZE    = 28;
    localparam int KERNEL_SIZE = 5;
    localparam int NUM_FILTERS = 6;
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;

    localparam int PAD         = KERNEL_SIZE / 2;
    localparam int NUM_WEIGHTS = KERNEL_SIZE * KERNEL_SIZE * NUM_FILTERS;
    localparam int NUM_PIXELS  = IMG_SIZE * IMG_SIZE;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 8;
    localparam int COORD_W  = 5;
    localparam int FEAT_W   = 15;
    localparam int FILT_W   = 3;
    localparam int TAP_W    = $clog2(KERNEL_SIZE);
    localparam int WGT_AW   = $clog2(NUM_WEIGHTS);
    localparam int BIAS_AW  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int PIX_AW   = $clog2(NUM_PIXELS);
    // signed window coordinate: coordinate plus tap minus pad, one sign bit
    localparam int WIN_W    = COORD_W + 2;

    // stream payload layout
    localparam int S_FIELDS_W = IDX_W + 2 * COORD_W + 16;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((FEAT_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = FILT_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_WEIGHT = 2'd0,
        FUNC_WR_BIAS   = 2'd1,
        FUNC_WR_PIXEL  = 2'd2,
        FUNC_COMPUTE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic wr_item;      // store the accepted write request
        logic load_pos;     // latch position, clear filter, taps and accumulator
        logic issue;        // read one tap and advance the tap counters
        logic next_filter;  // advance filter, clear taps and accumulator
        logic load_out;     // move the finished result into the output register
    } cpr_cmd_t;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
        logic last_filter;
        logic out_free;
    } cpr_status_t;

endpackage

@@ hw/rtl/cpr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cpr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: takes requests, runs the tap loop per filter, hands off results.
// ----------------------------------------------------------------------------
module cpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpr_pkg::func_t      func,
    input  cpr_pkg::cpr_status_t status,
    output cpr_pkg::cpr_cmd_t   cmd
);
    import cpr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // ready is high throughout idle, so valid alone marks a request
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (func) inside
                        FUNC_COMPUTE:
                        begin
                            cmd.load_pos = 1'b1;
                            state_next   = ST_MAC;
                        end
                        default:
                        begin
                            cmd.wr_item = 1'b1;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // let the multiply pipeline drain into the accumulator
                if (!status.pipe_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.last_filter)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_filter = 1'b1;
                        state_next      = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/cpr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_datapath
// Stores, tap address generation, shared multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module cpr_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpr_pkg::cpr_cmd_t            cmd,
    output cpr_pkg::cpr_status_t         status,
    input  cpr_pkg::func_t               func,
    input  logic [cpr_pkg::IDX_W-1:0]    coef_index,
    input  logic [cpr_pkg::COORD_W-1:0]  row,
    input  logic [cpr_pkg::COORD_W-1:0]  col,
    input  logic [15:0]                  value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cpr_pkg::FEAT_W-1:0]   feature_value,
    output logic [cpr_pkg::FILT_W-1:0]   filter_number,
    output logic                         last
);
    import cpr_pkg::*;

    // position and loop counters
    logic [COORD_W-1:0] pos_row_reg;
    logic [COORD_W-1:0] pos_col_reg;
    logic [TAP_W-1:0]   fr_reg;
    logic [TAP_W-1:0]   fc_reg;
    logic [FILT_W-1:0]  filt_reg;

    // pipeline
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          pad1_reg;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic [DATA_WIDTH-1:0]         acc_reg;

    // output register
    logic              out_valid_reg;
    logic [FEAT_W-1:0] out_feat_reg;
    logic [FILT_W-1:0] out_filt_reg;
    logic              out_last_reg;

    // store ports
    logic [DATA_WIDTH-1:0] wr_value;
    logic                  wgt_we;
    logic                  bias_we;
    logic                  pix_we;
    logic [WGT_AW-1:0]     wgt_waddr;
    logic [BIAS_AW-1:0]    bias_waddr;
    logic [PIX_AW-1:0]     pix_waddr;
    logic [WGT_AW-1:0]     wgt_raddr;
    logic [BIAS_AW-1:0]    bias_raddr;
    logic [PIX_AW-1:0]     pix_raddr;
    logic [DATA_WIDTH-1:0] wgt_rdata;
    logic [DATA_WIDTH-1:0] bias_rdata;
    logic [DATA_WIDTH-1:0] pix_rdata;

    logic [WIN_W-1:0]      win_r;
    logic [WIN_W-1:0]      win_c;
    logic                  win_pad;
    logic [DATA_WIDTH-1:0] px;
    logic [DATA_WIDTH-1:0] total;
    logic                  last_tap;

    // write decode; out-of-range writes are dropped
    assign wr_value   = DATA_WIDTH'($signed(value));
    assign wgt_we     = cmd.wr_item && (func == FUNC_WR_WEIGHT) && (coef_index < NUM_WEIGHTS);
    assign bias_we    = cmd.wr_item && (func == FUNC_WR_BIAS) && (coef_index < NUM_FILTERS);
    assign pix_we     = cmd.wr_item && (func == FUNC_WR_PIXEL)
                        && (row < IMG_SIZE) && (col < IMG_SIZE);
    assign wgt_waddr  = WGT_AW'(coef_index);
    assign bias_waddr = BIAS_AW'(coef_index);
    assign pix_waddr  = PIX_AW'(row * IMG_SIZE + col);

    // tap addresses: window coordinate wraps negative above the pad edge
    assign win_r     = WIN_W'(pos_row_reg) + WIN_W'(fr_reg) - WIN_W'(PAD);
    assign win_c     = WIN_W'(pos_col_reg) + WIN_W'(fc_reg) - WIN_W'(PAD);
    assign win_pad   = win_r[WIN_W-1] || win_c[WIN_W-1]
                       || (win_r[WIN_W-2:0] >= IMG_SIZE) || (win_c[WIN_W-2:0] >= IMG_SIZE);
    assign pix_raddr = PIX_AW'(win_r[WIN_W-2:0] * IMG_SIZE + win_c[WIN_W-2:0]);
    assign wgt_raddr = WGT_AW'(fr_reg * (KERNEL_SIZE * NUM_FILTERS)
                               + fc_reg * NUM_FILTERS + filt_reg);
    assign bias_raddr = BIAS_AW'(filt_reg);

    assign last_tap = (fr_reg == TAP_W'(KERNEL_SIZE - 1)) && (fc_reg == TAP_W'(KERNEL_SIZE - 1));

    cpr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_WEIGHTS)) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wr_value),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    cpr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_FILTERS)) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (bias_waddr),
        .wdata (wr_value),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    cpr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_PIXELS)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (wr_value),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // counters and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_reg        <= '0;
            fc_reg        <= '0;
            filt_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.load_pos || cmd.next_filter)
            begin
                fr_reg <= '0;
                fc_reg <= '0;
            end
            else if (cmd.issue)
            begin
                if (fc_reg == TAP_W'(KERNEL_SIZE - 1))
                begin
                    fc_reg <= '0;
                    fr_reg <= fr_reg + TAP_W'(1);
                end
                else
                begin
                    fc_reg <= fc_reg + TAP_W'(1);
                end
            end
            if (cmd.load_pos)
            begin
                filt_reg <= '0;
            end
            else if (cmd.next_filter)
            begin
                filt_reg <= filt_reg + FILT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign px    = pad1_reg ? '0 : pix_rdata;
    assign total = acc_reg + bias_rdata;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_pos)
        begin
            pos_row_reg <= row;
            pos_col_reg <= col;
        end
        pad1_reg <= win_pad;
        prod_reg <= $signed(wgt_rdata) * $signed(px);
        // floor of the product to FRAC_BITS fraction bits, wrapped sum
        if (cmd.load_pos || cmd.next_filter)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg[FRAC_BITS +: DATA_WIDTH];
        end
        if (cmd.load_out)
        begin
            out_feat_reg <= total[DATA_WIDTH-1] ? '0 : total[FEAT_W-1:0];
            out_filt_reg <= filt_reg;
            out_last_reg <= (filt_reg == FILT_W'(NUM_FILTERS - 1));
        end
    end

    assign status.last_tap    = last_tap;
    assign status.pipe_busy   = v1_reg || v2_reg;
    assign status.last_filter = (filt_reg == FILT_W'(NUM_FILTERS - 1));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign feature_value = out_feat_reg;
    assign filter_number = out_filt_reg;
    assign last          = out_last_reg;

endmodule

@@ hw/rtl/conv5x5_padded_relu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv5x5_padded_relu_core
// 5x5 zero-padded convolution, six filters, bias and ReLU over a 28x28 image.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries requests; s_tuser selects the kind. Weight, bias
//   and pixel writes go into on-chip stores, back to back while idle. A compute
//   request at (row, col) produces six results on the master stream, one per
//   filter in order, m_tlast on the sixth.
//   Each filter runs 25 multiply-accumulates on one shared multiplier fed from
//   the weight and pixel RAMs, then drains the read/multiply pipeline into the
//   accumulator and adds the bias as the result is loaded into the output
//   register. m_tvalid of the first result rises once the first filter is
//   finished.
//   s_tready is high only while no compute request is in progress.
//   A finished result sits in an output register; the next filter starts
//   while it waits. A stalled receiver holds the core at the end of the
//   following filter until the register frees.
//   Reset clears the sequencer and the output valid; the stores keep their
//   contents and must be written before they are read.
// ----------------------------------------------------------------------------
module conv5x5_padded_relu_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] coef_index, [12:8] row, [17:13] col, [33:18] value, rest zero
    input  logic [cpr_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] func
    input  logic [cpr_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [14:0] feature_value, [15] zero
    output logic [cpr_pkg::M_TDATA_W-1:0]   m_tdata,
    // [2:0] filter_number
    output logic [cpr_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import cpr_pkg::*;

    func_t              func;
    logic [IDX_W-1:0]   coef_index;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [15:0]        value;
    logic [FEAT_W-1:0]  feature_value;
    cpr_cmd_t           cmd;
    cpr_status_t        status;

    // unpack the request
    assign func       = func_t'(s_tuser);
    assign coef_index = s_tdata[IDX_W-1:0];
    assign row        = s_tdata[IDX_W +: COORD_W];
    assign col        = s_tdata[IDX_W + COORD_W +: COORD_W];
    assign value      = s_tdata[IDX_W + 2 * COORD_W +: 16];

    cpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    cpr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .coef_index    (coef_index),
        .row           (row),
        .col           (col),
        .value         (value),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .feature_value (feature_value),
        .filter_number (m_tuser),
        .last          (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(feature_value);

endmodule

@@ hw/rtl/cpr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
module cpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [cpr_pkg::FUNC_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cpr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cpr_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import cpr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a compute request blocks further requests
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_COMPUTE) |=> !s_tready)
        else $error("request taken during compute");

    // last flag marks exactly the final filter
    a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == M_TUSER_W'(NUM_FILTERS - 1))))
        else $error("last flag on wrong filter");

    // ReLU output never carries the sign bit
    a_relu: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:FEAT_W] == '0))
        else $error("result above positive range");

endmodule

bind conv5x5_padded_relu_core cpr_checker u_cpr_checker (.*);

@@ tb/sv/conv5x5_padded_relu_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv5x5_padded_relu_core_tb
// Self-checking stream testbench for the padded 5x5 convolution core.
// Fills the weight and bias stores and the top image rows, then runs a table
// of directed requests and a random mix of store writes and compute requests.
// Random gaps are applied on both streams. Each compute request is scored
// filter by filter against its spelled-out table results or a local
// fixed-point predictor of the window sum, bias and ReLU.
// ----------------------------------------------------------------------------
module conv5x5_padded_relu_core_tb;

    import cpr_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int FILL_ROWS    = 4;
    localparam int RANDOM_ITEMS = 30;
    localparam int PAUSE_AT     = 15;
    localparam int DRAIN_CYCLES = 200;
    localparam int TIMEOUT_NS   = 3_000_000;
    localparam int N_DIRECTED   = 26;

    typedef logic [0:NUM_FILTERS-1][FEAT_W-1:0] feat_row_t;

    // one result as it leaves the master stream
    typedef struct packed {
        logic [FEAT_W-1:0] feat;
        logic [FILT_W-1:0] filt;
        logic              last;
    } feature_t;

    // one directed request; typed rows carry their results spelled out
    typedef struct packed {
        func_t              fn;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [15:0]        val;
        logic               typed;
        feat_row_t          feat;
    } directed_req_t;

    // window fully off the image: each filter returns ReLU of its bias
    localparam feat_row_t BIAS_ONLY = {15'd32767, 15'd0, 15'd0, 15'd1, 15'd0, 15'd12345};
    localparam feat_row_t NO_FEAT   = '0;

    localparam directed_req_t DIRECTED_TBL [N_DIRECTED] = '{
        // bias extremes, one per filter
        '{FUNC_WR_BIAS,   8'd0,   5'd0,  5'd0,  16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd1,   5'd0,  5'd0,  16'h8000, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd2,   5'd0,  5'd0,  16'h0000, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd3,   5'd0,  5'd0,  16'h0001, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd4,   5'd0,  5'd0,  16'hFFFF, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd5,   5'd0,  5'd0,  16'h3039, 1'b0, NO_FEAT},
        // positions beyond the image see only padding
        '{FUNC_COMPUTE,   8'd0,   5'd31, 5'd31, 16'h0000, 1'b1, BIAS_ONLY},
        '{FUNC_COMPUTE,   8'd255, 5'd30, 5'd0,  16'hFFFF, 1'b1, BIAS_ONLY},
        // writes beyond each store are dropped
        '{FUNC_WR_WEIGHT, 8'd150, 5'd0,  5'd0,  16'h1234, 1'b0, NO_FEAT},
        '{FUNC_WR_WEIGHT, 8'd255, 5'd31, 5'd31, 16'hFFFF, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd6,   5'd0,  5'd0,  16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_BIAS,   8'd255, 5'd0,  5'd0,  16'h8000, 1'b0, NO_FEAT},
        '{FUNC_WR_PIXEL,  8'd0,   5'd28, 5'd0,  16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_PIXEL,  8'd0,   5'd0,  5'd31, 16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_PIXEL,  8'd255, 5'd31, 5'd31, 16'h8000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd0,  5'd31, 16'h0000, 1'b1, BIAS_ONLY},
        // store extremes, then the top corners, the top edge and a window
        // that holds only the bottom-right pixel
        '{FUNC_WR_WEIGHT, 8'd0,   5'd0,  5'd0,  16'h8000, 1'b0, NO_FEAT},
        '{FUNC_WR_WEIGHT, 8'd149, 5'd0,  5'd0,  16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_PIXEL,  8'd0,   5'd0,  5'd0,  16'h7FFF, 1'b0, NO_FEAT},
        '{FUNC_WR_PIXEL,  8'd0,   5'd27, 5'd27, 16'h8000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd0,  5'd0,  16'h0000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd1,  5'd27, 16'h0000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd0,  5'd27, 16'h0000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd1,  5'd0,  16'h0000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd29, 5'd29, 16'h0000, 1'b0, NO_FEAT},
        '{FUNC_COMPUTE,   8'd0,   5'd1,  5'd14, 16'h0000, 1'b0, NO_FEAT}
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // local image of the core's stores, written as each request is accepted
    logic signed [DATA_WIDTH-1:0] weight_mem [NUM_WEIGHTS];
    logic signed [DATA_WIDTH-1:0] bias_mem   [NUM_FILTERS];
    logic signed [DATA_WIDTH-1:0] pixel_mem  [NUM_PIXELS];

    feature_t feature_q [$];
    int       n_errors = 0;
    bit       quiet    = 1'b0;   // suppress all gaps on both streams

    conv5x5_padded_relu_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix of extremes, small values that keep sums in range, and full range.
    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 60)
            return 16'($signed($urandom_range(0, 1200)) - 600);
        return 16'($urandom);
    endfunction

    // Expected results of a compute request at (row, col): for each filter
    // sum the floored products over the padded window, add the bias with
    // 16-bit wrap, then clamp negatives to zero.
    function automatic void predict_features(input logic [COORD_W-1:0] row,
                                             input logic [COORD_W-1:0] col);
        logic signed [DATA_WIDTH-1:0]   acc;
        logic signed [DATA_WIDTH-1:0]   px;
        logic signed [2*DATA_WIDTH-1:0] prod;
        int                             pr;
        int                             pc;
        feature_t                       res;
        for (int f = 0; f < NUM_FILTERS; f++)
        begin
            acc = '0;
            for (int fr = 0; fr < KERNEL_SIZE; fr++)
            begin
                for (int fc = 0; fc < KERNEL_SIZE; fc++)
                begin
                    pr = int'(row) + fr - PAD;
                    pc = int'(col) + fc - PAD;
                    if (pr < 0 || pc < 0 || pr >= IMG_SIZE || pc >= IMG_SIZE)
                        px = '0;
                    else
                        px = pixel_mem[pr * IMG_SIZE + pc];
                    prod = weight_mem[fr * KERNEL_SIZE * NUM_FILTERS + fc * NUM_FILTERS + f]
                           * px;
                    // arithmetic shift floors, then the sum wraps to 16 bits
                    acc = acc + prod[FRAC_BITS +: DATA_WIDTH];
                end
            end
            acc = acc + bias_mem[f];
            res.feat = acc[DATA_WIDTH-1] ? '0 : FEAT_W'(acc);
            res.filt = FILT_W'(f);
            res.last = (f == NUM_FILTERS - 1);
            feature_q.push_back(res);
        end
    endfunction

    // Present one request, hold it until accepted, then apply it to the
    // local stores or queue the results it will produce. Entered and left
    // at a rising edge; tvalid stays high straight into the next request
    // when no gap is drawn.
    task automatic send_request(input func_t              fn,
                                input logic [IDX_W-1:0]   idx,
                                input logic [COORD_W-1:0] row,
                                input logic [COORD_W-1:0] col,
                                input logic [15:0]        val,
                                input logic               typed,
                                input feat_row_t          typed_feat);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        feature_t             res;
        gap  = pick_gap();
        word = '0;
        word[0 +: IDX_W]                   = idx;
        word[IDX_W +: COORD_W]             = row;
        word[IDX_W + COORD_W +: COORD_W]   = col;
        word[IDX_W + 2 * COORD_W +: 16]    = val;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_tready);

        case (fn)
            FUNC_WR_WEIGHT:
                if (idx < NUM_WEIGHTS)
                    weight_mem[idx] = $signed(val);
            FUNC_WR_BIAS:
                if (idx < NUM_FILTERS)
                    bias_mem[idx] = $signed(val);
            FUNC_WR_PIXEL:
                if (row < IMG_SIZE && col < IMG_SIZE)
                    pixel_mem[row * IMG_SIZE + col] = $signed(val);
            default:
                if (typed)
                begin
                    for (int f = 0; f < NUM_FILTERS; f++)
                    begin
                        res.feat = typed_feat[f];
                        res.filt = FILT_W'(f);
                        res.last = (f == NUM_FILTERS - 1);
                        feature_q.push_back(res);
                    end
                end
                else
                begin
                    predict_features(row, col);
                end
        endcase
    endtask

    // Drop tvalid and hold the sender until every queued result is back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (feature_q.size() != 0)
            @(posedge clk);
    endtask

    // Score one accepted result against the oldest expectation.
    task automatic check_feature();
        feature_t want;
        if (feature_q.size() == 0)
        begin
            $error("unexpected result: feature_value %0d filter_number %0d last %0d",
                   m_tdata[FEAT_W-1:0], m_tuser, m_tlast);
            n_errors++;
            return;
        end
        want = feature_q.pop_front();
        if (m_tdata[FEAT_W-1:0] !== want.feat)
        begin
            $error("feature_value: expected %0d, got %0d", want.feat, m_tdata[FEAT_W-1:0]);
            n_errors++;
        end
        if (m_tdata[M_TDATA_W-1:FEAT_W] !== '0)
        begin
            $error("m_tdata pad: expected 0, got %0d", m_tdata[M_TDATA_W-1:FEAT_W]);
            n_errors++;
        end
        if (m_tuser !== want.filt)
        begin
            $error("filter_number: expected %0d, got %0d", want.filt, m_tuser);
            n_errors++;
        end
        if (m_tlast !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            n_errors++;
        end
    endtask

    // Result side: score each accepted result, then stall for a random
    // number of cycles before taking the next one.
    initial
    begin : result_sink
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_feature();
                stall = pick_gap();
            end
            else if (stall > 0)
            begin
                stall--;
            end
            m_tready <= (stall == 0);
        end
    end

    // Request side: fill the stores, walk the directed table, then the
    // random mix.
    initial
    begin : request_source
        int                 n_done;
        int                 kind;
        bit                 paused;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write every weight and bias and the top image rows; computes are
        // kept to positions whose windows see only these rows, written pixels or padding.
        for (int i = 0; i < NUM_WEIGHTS; i++)
            send_request(FUNC_WR_WEIGHT, IDX_W'(i), COORD_W'($urandom), COORD_W'($urandom),
                         pick_value(), 1'b0, NO_FEAT);
        for (int i = 0; i < NUM_FILTERS; i++)
            send_request(FUNC_WR_BIAS, IDX_W'(i), COORD_W'($urandom), COORD_W'($urandom),
                         pick_value(), 1'b0, NO_FEAT);
        for (int r = 0; r < FILL_ROWS; r++)
            for (int c = 0; c < IMG_SIZE; c++)
                send_request(FUNC_WR_PIXEL, IDX_W'($urandom), COORD_W'(r), COORD_W'(c),
                             pick_value(), 1'b0, NO_FEAT);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED_TBL[i].fn, DIRECTED_TBL[i].idx, DIRECTED_TBL[i].row,
                         DIRECTED_TBL[i].col, DIRECTED_TBL[i].val, DIRECTED_TBL[i].typed,
                         DIRECTED_TBL[i].feat);
        wait_results_drained();

        // Random mix. Only requests that change a store or compute count;
        // out-of-range writes ride along as noise.
        n_done = 0;
        paused = 1'b0;
        while (n_done < RANDOM_ITEMS)
        begin
            quiet = (n_done >= 20 && n_done < 25);
            kind  = $urandom_range(0, 99);
            idx   = IDX_W'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                row = COORD_W'($urandom);
                col = COORD_W'($urandom);
            end
            else
            begin
                row = COORD_W'($urandom_range(0, IMG_SIZE - 1));
                col = COORD_W'($urandom_range(0, IMG_SIZE - 1));
            end

            if (kind < 35)
            begin
                // top rows, or rows so far down that the window is all padding
                if ($urandom_range(0, 1) == 0)
                    row = COORD_W'($urandom_range(0, FILL_ROWS - 1 - PAD));
                else
                    row = COORD_W'($urandom_range(IMG_SIZE + PAD, (1 << COORD_W) - 1));
                col = COORD_W'($urandom);
                send_request(FUNC_COMPUTE, idx, row, col, 16'($urandom), 1'b0, NO_FEAT);
                n_done++;
            end
            else if (kind < 60)
            begin
                send_request(FUNC_WR_PIXEL, idx, row, col, pick_value(), 1'b0, NO_FEAT);
                if (row < IMG_SIZE && col < IMG_SIZE)
                    n_done++;
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 9) != 0)
                    idx = IDX_W'($urandom_range(0, NUM_WEIGHTS - 1));
                send_request(FUNC_WR_WEIGHT, idx, row, col, pick_value(), 1'b0, NO_FEAT);
                if (idx < NUM_WEIGHTS)
                    n_done++;
            end
            else
            begin
                if ($urandom_range(0, 6) != 0)
                    idx = IDX_W'($urandom_range(0, NUM_FILTERS - 1));
                send_request(FUNC_WR_BIAS, idx, row, col, pick_value(), 1'b0, NO_FEAT);
                if (idx < NUM_FILTERS)
                    n_done++;
            end

            if (n_done >= PAUSE_AT && !paused)
            begin
                paused = 1'b1;
                wait_results_drained();
            end
        end
        quiet = 1'b0;

        // Let the last results out, then watch for strays.
        s_tvalid <= 1'b0;
        while (feature_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
